FILE: hw/rtl/slcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slcp_pkg;

  localparam logic [7:0] SYNC_BYTE       = 8'd170;
  localparam logic [7:0] MAX_LEN         = 8'd169;
  localparam logic [7:0] DEFAULT_QUALITY = 8'd200;
  localparam logic [7:0] CODE_QUALITY    = 8'd2;
  localparam logic [7:0] CODE_ATTENTION  = 8'd4;
  localparam logic [7:0] CODE_MEDITATION = 8'd5;
  localparam logic [7:0] CODE_SKIP_SHORT = 8'h80;
  localparam logic [7:0] CODE_SKIP_LONG  = 8'h83;
  localparam logic [4:0] SKIP_SHORT      = 5'd3;
  localparam logic [4:0] SKIP_LONG       = 5'd25;

  typedef enum logic [4:0] {
    FR_HUNT1   = 5'b00001,
    FR_HUNT2   = 5'b00010,
    FR_LEN     = 5'b00100,
    FR_PAYLOAD = 5'b01000,
    FR_CHECK   = 5'b10000
  } frame_phase_t;

  typedef enum logic [4:0] {
    FD_CODE = 5'b00001,
    FD_QUAL = 5'b00010,
    FD_ATTN = 5'b00100,
    FD_MED  = 5'b01000,
    FD_SKIP = 5'b10000
  } field_phase_t;

  typedef struct packed {
    logic [7:0] quality;
    logic [7:0] attention;
    logic [7:0] meditation;
    logic       seen;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/slcp_core.sv
`timescale 1ns / 1ps
`default_nettype none
module slcp_core
  import slcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output logic            hit,
  output result_t         result
);

  frame_phase_t frame_phase, frame_phase_next;
  field_phase_t field_phase, field_phase_next;
  logic [7:0]   bytes_left, bytes_left_next;
  logic [7:0]   running_sum, running_sum_next;
  logic [4:0]   skip_left, skip_left_next;
  result_t      shadow, shadow_next;
  logic [7:0]   bytes_dec;
  logic [4:0]   skip_dec;

  always_comb begin
    frame_phase_next = frame_phase;
    field_phase_next = field_phase;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    skip_left_next   = skip_left;
    shadow_next      = shadow;
    hit              = 1'b0;
    bytes_dec        = (bytes_left != 8'd0) ? bytes_left - 8'd1 : bytes_left;
    skip_dec         = (skip_left != 5'd0) ? skip_left - 5'd1 : skip_left;

    case (frame_phase)
      FR_HUNT2: begin
        frame_phase_next = (rx_byte == SYNC_BYTE) ? FR_LEN : FR_HUNT1;
      end
      FR_LEN: begin
        if (rx_byte > MAX_LEN) begin
          frame_phase_next = FR_HUNT1;
        end else begin
          bytes_left_next    = rx_byte;
          running_sum_next   = 8'd0;
          field_phase_next   = FD_CODE;
          skip_left_next     = 5'd0;
          shadow_next        = '{quality: DEFAULT_QUALITY, attention: 8'd0,
                                 meditation: 8'd0, seen: 1'b0};
          frame_phase_next   = (rx_byte == 8'd0) ? FR_CHECK : FR_PAYLOAD;
        end
      end
      FR_PAYLOAD: begin
        running_sum_next = running_sum + rx_byte;
        bytes_left_next  = bytes_dec;
        if (bytes_dec == 8'd0) begin
          frame_phase_next = FR_CHECK;
        end
        case (field_phase)
          FD_QUAL: begin
            shadow_next.quality = rx_byte;
            shadow_next.seen    = 1'b1;
            field_phase_next    = FD_CODE;
          end
          FD_ATTN: begin
            shadow_next.attention = rx_byte;
            field_phase_next      = FD_CODE;
          end
          FD_MED: begin
            shadow_next.meditation = rx_byte;
            field_phase_next       = FD_CODE;
          end
          FD_SKIP: begin
            skip_left_next = skip_dec;
            if (skip_dec == 5'd0) begin
              field_phase_next = FD_CODE;
            end
          end
          default: begin
            case (rx_byte)
              CODE_QUALITY:    field_phase_next = FD_QUAL;
              CODE_ATTENTION:  field_phase_next = FD_ATTN;
              CODE_MEDITATION: field_phase_next = FD_MED;
              CODE_SKIP_SHORT: begin
                field_phase_next = FD_SKIP;
                skip_left_next   = SKIP_SHORT;
              end
              CODE_SKIP_LONG: begin
                field_phase_next = FD_SKIP;
                skip_left_next   = SKIP_LONG;
              end
              default:         field_phase_next = FD_CODE;
            endcase
          end
        endcase
      end
      FR_CHECK: begin
        hit              = (rx_byte == ~running_sum);
        frame_phase_next = FR_HUNT1;
        field_phase_next = FD_CODE;
        skip_left_next   = 5'd0;
      end
      default: begin
        frame_phase_next = (rx_byte == SYNC_BYTE) ? FR_HUNT2 : FR_HUNT1;
      end
    endcase
  end

  assign result = shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase <= FR_HUNT1;
      field_phase <= FD_CODE;
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
      skip_left   <= 5'd0;
      shadow      <= '{quality: DEFAULT_QUALITY, attention: 8'd0,
                       meditation: 8'd0, seen: 1'b0};
    end else if (step) begin
      frame_phase <= frame_phase_next;
      field_phase <= field_phase_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      skip_left   <= skip_left_next;
      shadow      <= shadow_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sync_length_checksum_packet_parser.sv
// An accepted word is registered in the input stage; its result is then registered in the output stage.
// Throughput: one word per cycle, sustained; stalls only when a result is held and stalled.
// The frame/field state update in the core is computed combinationally.
// Reset (rst, synchronous, active high): hunting for the first sync byte,
// shadow values 200/0/0, input and output stages empty.
`timescale 1ns / 1ps
`default_nettype none
module sync_length_checksum_packet_parser
  import slcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      signal_quality,
  output logic [7:0]      attention_level,
  output logic [7:0]      meditation_level,
  output logic            quality_seen
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       hit;
  result_t    result;
  result_t    out_res;

  assign in_stall = s1_valid && out_valid && out_stall;
  assign advance  = s1_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  slcp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .hit     (hit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_res <= result;
    end
  end

  assign signal_quality   = out_res.quality;
  assign attention_level  = out_res.attention;
  assign meditation_level = out_res.meditation;
  assign quality_seen     = out_res.seen;

`ifndef SYNTHESIS
  a_stall_keeps_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid)
    else $error("input stage lost a stalled word");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(s1_byte))
    else $error("input stage byte changed under stall");

  a_result_from_word: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared with no word in the input stage");
`endif

endmodule
`default_nettype wire
